// ===== design/efs_pkg.sv =====
// ----------------------------------------------------------------------------
// efs_pkg: shared definitions for the earliest-free-server scheduler
// Field widths, operation codes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package efs_pkg;

    // Parameter defaults
    localparam int DEF_SERVERS   = 8;
    localparam int DEF_TIME_BITS = 32;

    // Payload field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 3;
    localparam int COST_W     = 8;
    localparam int WORK_W     = 8;
    localparam int OUT_TIME_W = 32;
    localparam int ACT_W      = 4;
    localparam int DUR_W      = COST_W + WORK_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_JOB   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Reset values
    localparam logic [ACT_W-1:0]  ACT_RESET  = 4'd8;
    localparam logic [COST_W-1:0] COST_RESET = 8'd1;

endpackage

// ===== design/efs_req_if.sv =====
// ----------------------------------------------------------------------------
// efs_req_if: request channel of the scheduler
// Valid/ready channel carrying one operation and its operands.
// ----------------------------------------------------------------------------
interface efs_req_if;
    import efs_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  server_index;
    logic [COST_W-1:0] unit_cost;
    logic [WORK_W-1:0] work_units;

    modport source (output valid, output op, output server_index, output unit_cost,
                    output work_units, input ready);
    modport sink   (input valid, input op, input server_index, input unit_cost,
                    input work_units, output ready);
endinterface

// ===== design/efs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// efs_rsp_if: response channel of the scheduler
// Valid/ready channel carrying one job placement.
// ----------------------------------------------------------------------------
interface efs_rsp_if;
    import efs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      chosen_server;
    logic [OUT_TIME_W-1:0] start_time;
    logic [OUT_TIME_W-1:0] finish_time;
    logic [OUT_TIME_W-1:0] makespan;
    logic                  saturated;

    modport source (output valid, output chosen_server, output start_time,
                    output finish_time, output makespan, output saturated, input ready);
    modport sink   (input valid, input chosen_server, input start_time,
                    input finish_time, input makespan, input saturated, output ready);
endinterface

// ===== design/efs_ram.sv =====
// ----------------------------------------------------------------------------
// efs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module efs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/earliest_free_server_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// earliest_free_server_scheduler_top: list scheduler onto the earliest free server
// Keeps per-server free times and costs in RAM and places each job.
// ----------------------------------------------------------------------------
// A load or clear transaction completes when it is accepted. From acceptance of
// a job to the next acceptance, the free-time memory is scanned one entry per
// cycle through its single read port over the n active servers, then the
// duration is multiplied, added with saturation, and the result is written back
// and registered. A finished result may wait in the output register while loads
// and clears are taken; a next job is scanned but then waits for it to leave.
// Reset values of the free times and costs come from per-entry valid bits, so
// no clearing pass is needed after reset or on a clear transaction.
module earliest_free_server_scheduler_top #(
    parameter int SERVERS   = efs_pkg::DEF_SERVERS,
    parameter int TIME_BITS = efs_pkg::DEF_TIME_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [efs_pkg::ACT_W-1:0] cfg_wr_data,
    efs_req_if.sink                  req,
    efs_rsp_if.source                rsp
);
    import efs_pkg::*;

    localparam int SRV_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [ACT_W-1:0]     active_reg;
    logic [SERVERS-1:0]   free_valid_reg, cost_valid_reg;
    logic [SRV_W-1:0]     scan_idx_reg, last_reg, pend_idx_reg;
    logic                 pend_reg, samp_free_v_reg, samp_cost_v_reg;
    logic [WORK_W-1:0]    work_reg;
    logic [SRV_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_time_reg;
    logic [COST_W-1:0]    best_cost_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic [TIME_BITS-1:0] finish_reg;
    logic                 sat_reg;
    logic [TIME_BITS-1:0] latest_reg;
    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_server_reg;
    logic [TIME_BITS-1:0] out_start_reg, out_finish_reg, out_span_reg;
    logic                 out_sat_reg;

    logic                 req_fire, load_ok, done_fire;
    logic [SRV_W-1:0]     load_addr, last_idx;
    logic [ACT_W-1:0]     act_clip;
    logic [TIME_BITS-1:0] free_rdata, cur_time, new_latest;
    logic [COST_W-1:0]    cost_rdata, cur_cost;
    logic [TIME_BITS:0]   sum;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign load_ok   = req_fire && (req.op == OP_LOAD) && (32'(req.server_index) < SERVERS);
    assign load_addr = SRV_W'(req.server_index);
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // Clip the active count to 1..SERVERS
    always_comb
    begin
        if (active_reg == '0)
        begin
            act_clip = ACT_W'(1);
        end
        else if (32'(active_reg) > SERVERS)
        begin
            act_clip = ACT_W'(SERVERS);
        end
        else
        begin
            act_clip = active_reg;
        end
    end
    assign last_idx = SRV_W'(act_clip - ACT_W'(1));

    efs_ram #(.WIDTH(TIME_BITS), .DEPTH(SERVERS), .AW(SRV_W)) u_free_ram (
        .clk   (clk),
        .we    (done_fire),
        .waddr (best_idx_reg),
        .wdata (finish_reg),
        .raddr (scan_idx_reg),
        .rdata (free_rdata)
    );

    efs_ram #(.WIDTH(COST_W), .DEPTH(SERVERS), .AW(SRV_W)) u_cost_ram (
        .clk   (clk),
        .we    (load_ok),
        .waddr (load_addr),
        .wdata (req.unit_cost),
        .raddr (scan_idx_reg),
        .rdata (cost_rdata)
    );

    // Free times unset since reset/clear/load, and costs never loaded, read as reset
    assign cur_time = samp_free_v_reg ? free_rdata : '0;
    assign cur_cost = samp_cost_v_reg ? cost_rdata : COST_RESET;

    assign sum        = {1'b0, best_time_reg} + (TIME_BITS+1)'(dur_reg);
    assign new_latest = (finish_reg > latest_reg) ? finish_reg : latest_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.op == OP_JOB))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= ACT_RESET;
            free_valid_reg <= '0;
            cost_valid_reg <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            latest_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SCAN);
            if (cfg_wr_en)
            begin
                active_reg <= cfg_wr_data;
            end
            if (load_ok)
            begin
                cost_valid_reg[load_addr] <= 1'b1;
                free_valid_reg[load_addr] <= 1'b0;
            end
            if (req_fire && (req.op == OP_CLEAR))
            begin
                free_valid_reg <= '0;
                latest_reg     <= '0;
            end
            if (done_fire)
            begin
                free_valid_reg[best_idx_reg] <= 1'b1;
                latest_reg                   <= new_latest;
            end
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan datapath and result registers
    always_ff @(posedge clk)
    begin
        if (req_fire && (req.op == OP_JOB))
        begin
            scan_idx_reg <= '0;
            last_reg     <= last_idx;
            work_reg     <= req.work_units;
        end
        if (state_reg == ST_SCAN)
        begin
            pend_idx_reg    <= scan_idx_reg;
            samp_free_v_reg <= free_valid_reg[scan_idx_reg];
            samp_cost_v_reg <= cost_valid_reg[scan_idx_reg];
            if (scan_idx_reg != last_reg)
            begin
                scan_idx_reg <= scan_idx_reg + SRV_W'(1);
            end
        end
        // Keep the first strictly smaller free time, so ties go to the lowest index
        if (pend_reg && ((pend_idx_reg == '0) || (cur_time < best_time_reg)))
        begin
            best_idx_reg  <= pend_idx_reg;
            best_time_reg <= cur_time;
            best_cost_reg <= cur_cost;
        end
        if (state_reg == ST_MUL)
        begin
            dur_reg <= DUR_W'(best_cost_reg) * DUR_W'(work_reg);
        end
        if (state_reg == ST_ADD)
        begin
            sat_reg    <= sum[TIME_BITS];
            finish_reg <= sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        end
        if (done_fire)
        begin
            out_server_reg <= IDX_W'(best_idx_reg);
            out_start_reg  <= best_time_reg;
            out_finish_reg <= finish_reg;
            out_span_reg   <= new_latest;
            out_sat_reg    <= sat_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.chosen_server = out_server_reg;
    assign rsp.start_time    = OUT_TIME_W'(out_start_reg);
    assign rsp.finish_time   = OUT_TIME_W'(out_finish_reg);
    assign rsp.makespan      = OUT_TIME_W'(out_span_reg);
    assign rsp.saturated     = out_sat_reg;
endmodule

// ===== dv/efs_sched_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// efs_sched_checker: placement predictor and scoreboard for the scheduler
// Watches the request, response and configuration ports. Tracks per-server
// busy-until times, unit rates and the makespan, predicts each job placement
// and compares every accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
module efs_sched_checker #(
    parameter int SERVERS   = efs_pkg::DEF_SERVERS,
    parameter int TIME_BITS = efs_pkg::DEF_TIME_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [efs_pkg::ACT_W-1:0] cfg_wr_data,
    efs_req_if                        req,
    efs_rsp_if                        rsp,
    output int unsigned               mismatches,
    output int unsigned               outstanding
);
    import efs_pkg::*;

    localparam logic [63:0] TIME_TOP  = {64{1'b1}} >> (64 - TIME_BITS);
    localparam int unsigned PRINT_CAP = 100;

    typedef struct packed {
        logic [IDX_W-1:0]      server;
        logic [OUT_TIME_W-1:0] start;
        logic [OUT_TIME_W-1:0] finish;
        logic [OUT_TIME_W-1:0] makespan;
        logic                  sat;
    } placement_t;

    logic [TIME_BITS-1:0] busy_until [SERVERS];
    logic [COST_W-1:0]    unit_rate  [SERVERS];
    logic [TIME_BITS-1:0] span_high;
    logic [ACT_W-1:0]     active_count;
    placement_t           pending_placements [$];
    placement_t           want;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: placement mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Pick the earliest free active server and book the job on it.
    function automatic placement_t place_job(input logic [WORK_W-1:0] work);
        placement_t  p;
        int unsigned live;
        int unsigned best;
        int unsigned k;
        logic [63:0] start;
        logic [63:0] dur;
        logic [63:0] finish;
        if (active_count == 0)
            live = 1;
        else if (active_count > SERVERS)
            live = SERVERS;
        else
            live = active_count;
        best = 0;
        for (k = 1; k < live; k++)
            if (busy_until[k] < busy_until[best])
                best = k;
        start = 64'(busy_until[best]);
        dur   = 64'(unit_rate[best]) * 64'(work);
        if (start > TIME_TOP || dur > TIME_TOP - start)
        begin
            finish = TIME_TOP;
            p.sat  = 1'b1;
        end
        else
        begin
            finish = start + dur;
            p.sat  = 1'b0;
        end
        busy_until[best] = finish[TIME_BITS-1:0];
        if (finish > 64'(span_high))
            span_high = finish[TIME_BITS-1:0];
        p.server   = best[IDX_W-1:0];
        p.start    = start[OUT_TIME_W-1:0];
        p.finish   = finish[OUT_TIME_W-1:0];
        p.makespan = OUT_TIME_W'(span_high);
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SERVERS; k++)
            begin
                busy_until[k] = '0;
                unit_rate[k]  = COST_RESET;
            end
            span_high    = '0;
            active_count = ACT_RESET;
            pending_placements.delete();
            mismatches   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_placements.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result on server %0d, finish %0d",
                                              rsp.chosen_server, rsp.finish_time));
                end
                else
                begin
                    want = pending_placements.pop_front();
                    if (rsp.chosen_server !== want.server)
                        report_mismatch($sformatf("chosen_server got %0d expected %0d",
                                                  rsp.chosen_server, want.server));
                    if (rsp.start_time !== want.start)
                        report_mismatch($sformatf("start_time got %0d expected %0d",
                                                  rsp.start_time, want.start));
                    if (rsp.finish_time !== want.finish)
                        report_mismatch($sformatf("finish_time got %0d expected %0d",
                                                  rsp.finish_time, want.finish));
                    if (rsp.makespan !== want.makespan)
                        report_mismatch($sformatf("makespan got %0d expected %0d",
                                                  rsp.makespan, want.makespan));
                    if (rsp.saturated !== want.sat)
                        report_mismatch($sformatf("saturated got %0b expected %0b",
                                                  rsp.saturated, want.sat));
                end
            end

            if (cfg_wr_en)
                active_count = cfg_wr_data;

            if (req.valid && req.ready)
            begin
                case (req.op)
                    OP_LOAD:
                    begin
                        if (req.server_index < SERVERS)
                        begin
                            unit_rate[req.server_index]  = req.unit_cost;
                            busy_until[req.server_index] = '0;
                        end
                    end
                    OP_CLEAR:
                    begin
                        for (int k = 0; k < SERVERS; k++)
                            busy_until[k] = '0;
                        span_high = '0;
                    end
                    OP_JOB:
                        pending_placements.push_back(place_job(req.work_units));
                    default: ;
                endcase
            end

            outstanding = pending_placements.size();
        end
    end

endmodule

// ===== dv/earliest_free_server_scheduler_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// earliest_free_server_scheduler_top_tb: testbench for the scheduler top
// Drives directed and random load/job/clear transactions under several
// active-server settings and back-pressure mixes, then a run of jobs stacked
// on one server. Checking is done by efs_sched_checker.
// ----------------------------------------------------------------------------
module earliest_free_server_scheduler_top_tb;
    import efs_pkg::*;

    localparam real         CLK_PERIOD   = 12.0;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned SETTLE_CYC   = 16;
    localparam int unsigned RAND_PER_SET = 60;
    localparam int unsigned CLIMB_JOBS   = 12;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [ACT_W-1:0] cfg_wr_data;

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned quiet_cycles = 0;

    int unsigned      snd_tbl [3] = '{17, 58, 0};
    int unsigned      rcv_tbl [3] = '{58, 17, 0};
    logic [ACT_W-1:0] act_tbl [9] = '{4'd8, 4'd1, 4'd5, 4'd15, 4'd0, 4'd2, 4'd3, 4'd6, 4'd7};

    efs_req_if req_ch ();
    efs_rsp_if rsp_ch ();

    earliest_free_server_scheduler_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch.sink),
        .rsp         (rsp_ch.source)
    );

    efs_sched_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

    // Abort when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_wr_en)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("earliest_free_server_scheduler_top_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic send_op(input logic [OP_W-1:0]   op,
                           input logic [IDX_W-1:0]  idx,
                           input logic [COST_W-1:0] cost,
                           input logic [WORK_W-1:0] work);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct)
                @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.server_index <= idx;
        req_ch.unit_cost    <= cost;
        req_ch.work_units   <= work;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Hold off until every placement is back and the block has gone quiet.
    task automatic settle();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_active(input logic [ACT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_directed();
        send_op(OP_JOB, 3'd0, 8'd0, 8'd0);        // zero work on an idle server
        send_op(OP_JOB, 3'd7, 8'd255, 8'd255);    // all tied, lowest index wins
        send_op(OP_JOB, 3'd0, 8'd0, 8'd1);
        send_op(OP_LOAD, 3'd7, 8'd255, 8'd0);
        send_op(OP_LOAD, 3'd0, 8'd0, 8'd255);     // zero rate, jobs take no time
        send_op(OP_JOB, 3'd0, 8'd0, 8'd255);
        send_op(OP_UNUSED, 3'd7, 8'd255, 8'd255); // must be dropped
        send_op(OP_LOAD, 3'd3, 8'd128, 8'd0);
        repeat (8) send_op(OP_JOB, 3'd0, 8'd1, 8'd200);
        send_op(OP_CLEAR, 3'd7, 8'd255, 8'd255);
        send_op(OP_JOB, 3'd0, 8'd1, 8'd255);
        send_op(OP_JOB, 3'd0, 8'd1, 8'd255);
        send_op(OP_LOAD, 3'd0, 8'd1, 8'd0);
        send_op(OP_JOB, 3'd5, 8'd9, 8'd128);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned      done;
        int unsigned      pick;
        logic [OP_W-1:0] op;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
                op = OP_JOB;
            else if (pick < 82)
                op = OP_LOAD;
            else if (pick < 92)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            send_op(op, IDX_W'($urandom_range(7)), COST_W'($urandom_range(255)),
                    WORK_W'($urandom_range(255)));
            if (op != OP_UNUSED)
                done++;
        end
    endtask

    // Single active server at the top rate: stack jobs on it.
    task automatic run_climb();
        send_op(OP_LOAD, 3'd0, 8'd255, WORK_W'($urandom_range(255)));
        repeat (CLIMB_JOBS)
            send_op(OP_JOB, IDX_W'($urandom_range(7)), COST_W'($urandom_range(255)), 8'd255);
        send_op(OP_JOB, 3'd0, 8'd0, 8'd0);
        repeat (3)
            send_op(OP_JOB, IDX_W'($urandom_range(7)), COST_W'($urandom_range(255)),
                    WORK_W'($urandom_range(255)));
        send_op(OP_LOAD, 3'd0, 8'd17, 8'd0);
        send_op(OP_JOB, 3'd0, 8'd0, 8'd40);
        send_op(OP_CLEAR, 3'd0, 8'd0, 8'd0);
        send_op(OP_JOB, 3'd0, 8'd0, 8'd40);
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= OP_LOAD;
        req_ch.server_index <= '0;
        req_ch.unit_cost    <= '0;
        req_ch.work_units   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = snd_tbl[0];
        rcv_idle_pct = rcv_tbl[0];
        write_active(4'd8);
        run_directed();

        for (int m = 0; m < 3; m++)
        begin
            snd_idle_pct = snd_tbl[m];
            rcv_idle_pct = rcv_tbl[m];
            for (int c = 0; c < 3; c++)
            begin
                settle();
                write_active(act_tbl[3 * m + c]);
                run_random(RAND_PER_SET);
            end
        end

        settle();
        write_active(4'd0);
        run_climb();

        settle();
        if (mismatches == 0)
            $display("earliest_free_server_scheduler_top_tb: PASS");
        else
            $display("earliest_free_server_scheduler_top_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/efs_pkg.sv
design/efs_req_if.sv
design/efs_rsp_if.sv
design/efs_ram.sv
design/earliest_free_server_scheduler_top.sv
dv/efs_sched_checker.sv
dv/earliest_free_server_scheduler_top_tb.sv
